// ----- rtl/core/pfq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfq_pkg
// Shared operation and status codes for the PID queue with search.
// ----------------------------------------------------------------------------
package pfq_pkg;

    typedef enum logic [2:0] {
        OP_ENQUEUE  = 3'd0,
        OP_DEQUEUE  = 3'd1,
        OP_PEEK     = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_CONTAINS = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

// ----- rtl/core/pid_fifo_queue_with_search.sv -----
`timescale 1ns / 1ps
// Enqueue, dequeue, peek, clear: EXEC loads the result once the output is free.
// Contains: the scan reads one entry a cycle from the RAM.
// Throughput: one item at a time; next item is taken the cycle after a result
// is loaded into the output register. rst_n (async, active low) empties the
// queue; the entry RAM is not cleared and holds no valid bits.
// ----------------------------------------------------------------------------
// pid_fifo_queue_with_search
// FIFO of process identifiers kept in a ring of DEPTH RAM entries, with
// enqueue, dequeue, peek, clear and a sequential membership search.
// ----------------------------------------------------------------------------
module pid_fifo_queue_with_search #(
    parameter int DEPTH     = 64,
    parameter int PID_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   op,
    input  logic [PID_WIDTH-1:0]         pid_in,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [PID_WIDTH-1:0]         pid_out,
    output logic                         found,
    output logic [1:0]                   status,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic                         is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // One-hot sequencer: IDLE takes a transfer and issues the head read,
    // EXEC finishes the op (looping while a search scans or the output is stalled).
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // queue pointers
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg,  cnt_next;

    // latched item
    pfq_pkg::op_t   op_reg, op_next;
    logic [PID_WIDTH-1:0] pid_reg, pid_next;

    // search walker
    logic [AW-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [PID_WIDTH-1:0] pid_out_reg,   pid_out_next;
    logic                 found_reg,     found_next;
    pfq_pkg::status_t     status_reg,    status_next;
    logic [CW-1:0]        count_reg,     count_next;

    // RAM hookup
    logic                 wr_en;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [PID_WIDTH-1:0] rd_data;

    logic          in_xfer;
    logic          out_free;
    logic          finish;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] scan_inc;
    logic          q_empty;
    logic          q_full;

    pfq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (PID_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (pid_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ring increments, wrap at DEPTH-1 (DEPTH need not be a power of two)
    assign head_inc = (head_reg == AW'(DEPTH - 1))     ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == AW'(DEPTH - 1))     ? '0 : tail_reg + 1'b1;
    assign scan_inc = (scan_ptr_reg == AW'(DEPTH - 1)) ? '0 : scan_ptr_reg + 1'b1;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == CW'(DEPTH));

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    // result slot can be loaded when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        pid_next       = pid_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_idx_next  = scan_idx_reg;
        pid_out_next   = pid_out_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        finish         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    // latch item, fetch oldest entry for peek/dequeue/search
                    op_next       = pfq_pkg::op_t'(op);
                    pid_next      = pid_in;
                    rd_en         = 1'b1;
                    rd_addr       = head_reg;
                    scan_ptr_next = head_inc;
                    scan_idx_next = CW'(1);
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                pid_out_next = '0;
                found_next   = 1'b0;
                status_next  = pfq_pkg::ST_OK;

                unique case (op_reg)
                    pfq_pkg::OP_ENQUEUE:
                    begin
                        finish = out_free;
                        if (q_full)
                        begin
                            status_next = pfq_pkg::ST_FULL;
                        end
                        else if (out_free)
                        begin
                            wr_en     = 1'b1;
                            tail_next = tail_inc;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end

                    pfq_pkg::OP_DEQUEUE, pfq_pkg::OP_PEEK:
                    begin
                        finish = out_free;
                        if (q_empty)
                        begin
                            status_next = pfq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            pid_out_next = rd_data;
                            if (out_free && (op_reg == pfq_pkg::OP_DEQUEUE))
                            begin
                                head_next = head_inc;
                                cnt_next  = cnt_reg - 1'b1;
                            end
                        end
                    end

                    pfq_pkg::OP_CLEAR:
                    begin
                        finish = out_free;
                        if (out_free)
                        begin
                            head_next = '0;
                            tail_next = '0;
                            cnt_next  = '0;
                        end
                    end

                    pfq_pkg::OP_CONTAINS:
                    begin
                        // rd_data holds entry number scan_idx-1 from head
                        if (q_empty)
                        begin
                            finish = out_free;
                        end
                        else if (rd_data == pid_reg)
                        begin
                            found_next = 1'b1;
                            finish     = out_free;
                        end
                        else if (scan_idx_reg == cnt_reg)
                        begin
                            finish = out_free;
                        end
                        else
                        begin
                            // fetch the next entry and stay in EXEC
                            rd_en         = 1'b1;
                            rd_addr       = scan_ptr_reg;
                            scan_ptr_next = scan_inc;
                            scan_idx_next = scan_idx_reg + 1'b1;
                        end
                    end

                    default:
                    begin
                        // unused op codes leave the queue alone
                        finish = out_free;
                    end
                endcase

                if (finish)
                begin
                    out_valid_next = 1'b1;
                    count_next     = cnt_next;
                    state_next     = S_IDLE;
                end
                else
                begin
                    // hold the previous result fields while waiting
                    pid_out_next = pid_out_reg;
                    found_next   = found_reg;
                    status_next  = status_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pid_reg      <= pid_next;
        scan_ptr_reg <= scan_ptr_next;
        scan_idx_reg <= scan_idx_next;
        pid_out_reg  <= pid_out_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
    end

    assign out_valid = out_valid_reg;
    assign pid_out   = pid_out_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign is_empty  = (count_reg == '0);

endmodule

// ----- rtl/core/pfq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- tb/sv/pfq_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfq_scoreboard
// Watches both channels of the PID queue, keeps a shadow ring of the queue,
// predicts one reply per input transfer and compares each output transfer.
// ----------------------------------------------------------------------------
module pfq_scoreboard
    import pfq_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int PID_WIDTH = 16,
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [2:0]           op,
    input  logic [PID_WIDTH-1:0] pid_in,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [PID_WIDTH-1:0] pid_out,
    input  logic                 found,
    input  logic [1:0]           status,
    input  logic [CW-1:0]        count,
    input  logic                 is_empty,
    output int                   mismatches,
    output int                   outstanding,
    output int                   replies_checked,
    output int                   full_drops,
    output int                   empty_reads,
    output int                   search_hits
);

    typedef struct packed {
        logic [PID_WIDTH-1:0] pid;
        logic                 hit;
        logic [1:0]           st;
        logic [CW-1:0]        cnt;
        logic                 empty;
    } reply_t;

    reply_t                queued_replies[$];
    logic [PID_WIDTH-1:0]  shadow_ring [DEPTH];
    int                    shadow_head;
    int                    shadow_tail;
    int                    shadow_fill;

    // Applies one operation to the shadow ring and returns the reply.
    function automatic reply_t apply_queue_op(logic [2:0] code, logic [PID_WIDTH-1:0] id);
        reply_t r;
        int     pos;
        r = '0;
        r.st = ST_OK;
        case (code)
            OP_ENQUEUE:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    shadow_ring[shadow_tail] = id;
                    shadow_tail = (shadow_tail == DEPTH - 1) ? 0 : shadow_tail + 1;
                    shadow_fill++;
                end
            end
            OP_DEQUEUE, OP_PEEK:
            begin
                if (shadow_fill == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    r.pid = shadow_ring[shadow_head];
                    if (code == OP_DEQUEUE)
                    begin
                        shadow_head = (shadow_head == DEPTH - 1) ? 0 : shadow_head + 1;
                        shadow_fill--;
                    end
                end
            end
            OP_CLEAR:
            begin
                shadow_head = 0;
                shadow_tail = 0;
                shadow_fill = 0;
            end
            OP_CONTAINS:
            begin
                pos = shadow_head;
                for (int k = 0; k < shadow_fill; k++)
                begin
                    if (shadow_ring[pos] == id)
                    begin
                        r.hit = 1'b1;
                        break;
                    end
                    pos = (pos == DEPTH - 1) ? 0 : pos + 1;
                end
            end
            default:
            begin
            end
        endcase
        r.cnt   = CW'(shadow_fill);
        r.empty = (shadow_fill == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            queued_replies.delete();
            shadow_head     = 0;
            shadow_tail     = 0;
            shadow_fill     = 0;
            mismatches      = 0;
            replies_checked = 0;
            full_drops      = 0;
            empty_reads     = 0;
            search_hits     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (queued_replies.size() == 0)
                begin
                    $error("result transfer with no reply pending");
                    mismatches++;
                end
                else
                begin
                    want = queued_replies.pop_front();
                    replies_checked++;
                    if (want.st == ST_FULL)  full_drops++;
                    if (want.st == ST_EMPTY) empty_reads++;
                    if (want.hit)            search_hits++;
                    if (pid_out !== want.pid)
                    begin
                        $error("pid_out: expected %h, got %h", want.pid, pid_out);
                        mismatches++;
                    end
                    if (found !== want.hit)
                    begin
                        $error("found: expected %b, got %b", want.hit, found);
                        mismatches++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        mismatches++;
                    end
                    if (count !== want.cnt)
                    begin
                        $error("count: expected %0d, got %0d", want.cnt, count);
                        mismatches++;
                    end
                    if (is_empty !== want.empty)
                    begin
                        $error("is_empty: expected %b, got %b", want.empty, is_empty);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                queued_replies.push_back(apply_queue_op(op, pid_in));
        end
        outstanding = queued_replies.size();
    end

endmodule

// ----- tb/sv/pid_fifo_queue_with_search_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_fifo_queue_with_search_tb
// Drives directed and phase-shaped random operations into the PID queue,
// with random idle bursts on both channels; the scoreboard does the checking.
// ----------------------------------------------------------------------------
module pid_fifo_queue_with_search_tb;
    import pfq_pkg::*;

    localparam int DEPTH     = 64;
    localparam int PID_WIDTH = 16;
    localparam int CW        = $clog2(DEPTH + 1);

    // Random item budget, and the tail: phases begun in its last items run without idling.
    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_TAIL   = 150;
    // Worst item: full-queue search over all DEPTH entries plus a stall and a gap burst.
    localparam int CYCLE_LIMIT  = 500_000;

    // Op codes the block leaves undefined; they must change nothing.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // Random-phase flavors: each biases the op mix toward one region.
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_SEARCH, MIX_BALANCED } mix_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [2:0]           op        = OP_ENQUEUE;
    logic [PID_WIDTH-1:0] pid_in    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PID_WIDTH-1:0] pid_out;
    logic                 found;
    logic [1:0]           status;
    logic [CW-1:0]        count;
    logic                 is_empty;

    int   mismatches;
    int   outstanding;
    int   replies_checked;
    int   full_drops;
    int   empty_reads;
    int   search_hits;

    logic idle_on    = 1'b0;
    int   stall_left = 0;
    int   cycles     = 0;

    // Small set of identifiers so searches hit and duplicates pile up;
    // includes the all-zeros and all-ones corners.
    logic [PID_WIDTH-1:0] id_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                         16'h1234, 16'h00FF, 16'hFF00, 16'h5A5A};

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pid_fifo_queue_with_search #(
        .DEPTH     (DEPTH),
        .PID_WIDTH (PID_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .pid_in    (pid_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pid_out   (pid_out),
        .found     (found),
        .status    (status),
        .count     (count),
        .is_empty  (is_empty)
    );

    pfq_scoreboard #(
        .DEPTH     (DEPTH),
        .PID_WIDTH (PID_WIDTH),
        .CW        (CW)
    ) u_scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .pid_in          (pid_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pid_out         (pid_out),
        .found           (found),
        .status          (status),
        .count           (count),
        .is_empty        (is_empty),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .replies_checked (replies_checked),
        .full_drops      (full_drops),
        .empty_reads     (empty_reads),
        .search_hits     (search_hits)
    );

    // Result-side backpressure: random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d replies still pending",
                     cycles, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One transfer on the input channel, optionally preceded by an idle burst.
    // Called and returns at a rising edge.
    task automatic push_item(input logic [2:0] code, input logic [PID_WIDTH-1:0] id);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        pid_in   <= id;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Hold off the sender until every reply has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [PID_WIDTH-1:0] pick_id();
        if ($urandom_range(0, 1) == 0)
            return id_pool[$urandom_range(0, 7)];
        return PID_WIDTH'($urandom);
    endfunction

    function automatic logic [2:0] pick_op(mix_t mix);
        int r;
        int enq;
        int deq;
        int pk;
        int srch;
        r = $urandom_range(0, 99);
        // cumulative thresholds; clear takes 3 %, the rest goes to unused codes
        case (mix)
            MIX_FILL:   begin enq = 70; deq = 80; pk = 85; srch = 95; end
            MIX_DRAIN:  begin enq = 20; deq = 60; pk = 70; srch = 90; end
            MIX_SEARCH: begin enq = 30; deq = 45; pk = 50; srch = 94; end
            default:    begin enq = 40; deq = 65; pk = 75; srch = 92; end
        endcase
        if (r < enq)      return OP_ENQUEUE;
        if (r < deq)      return OP_DEQUEUE;
        if (r < pk)       return OP_PEEK;
        if (r < srch)     return OP_CONTAINS;
        if (r < srch + 3) return OP_CLEAR;
        return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    initial
    begin
        int          sent;
        int          phase_len;
        int          phase_no;
        mix_t        mix;
        logic [2:0]  code;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: empty-queue corners first
        push_item(OP_DEQUEUE,  16'h0000);
        push_item(OP_PEEK,     16'hFFFF);
        push_item(OP_CONTAINS, 16'h0000);   // search on empty queue: no hit, ok status
        // field extremes, then hits and a miss
        push_item(OP_ENQUEUE,  16'h0000);
        push_item(OP_ENQUEUE,  16'hFFFF);
        push_item(OP_ENQUEUE,  16'h5A5A);
        push_item(OP_PEEK,     16'h0000);
        push_item(OP_CONTAINS, 16'hFFFF);
        push_item(OP_CONTAINS, 16'h1234);
        push_item(OP_CONTAINS, 16'h0000);
        push_item(OP_DEQUEUE,  16'h0000);
        push_item(OP_DEQUEUE,  16'hFFFF);
        // unused codes must leave the queue as it is
        for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
            push_item(3'(c), 16'hFFFF);
        push_item(OP_DEQUEUE,  16'h0000);
        push_item(OP_DEQUEUE,  16'h0000);   // underflow
        push_item(OP_ENQUEUE,  16'hAAAA);
        push_item(OP_ENQUEUE,  16'h5555);
        push_item(OP_CLEAR,    16'h0000);
        push_item(OP_PEEK,     16'h0000);   // nothing left after clear
        push_item(OP_CONTAINS, 16'hAAAA);   // stale entry must not match
        push_item(OP_ENQUEUE,  16'h8001);
        push_item(OP_DEQUEUE,  16'h0000);
        wait_drained();

        // ---- random phases; the first one is biased toward filling the queue
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase_no == 0)
                mix = MIX_FILL;
            else
                mix = mix_t'($urandom_range(0, 3));
            phase_len = $urandom_range(40, 120);
            // some phases run with no idling at all; phases begun in the tail never idle
            idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                code = pick_op(mix);
                push_item(code, pick_id());
                if (code <= OP_CONTAINS)
                    sent++;
            end
            if (phase_no == 0 || $urandom_range(0, 3) == 0)
                wait_drained();
            phase_no++;
        end
        idle_on = 1'b0;

        // ---- drain, then let any search in flight finish
        wait_drained();
        repeat (DEPTH + 4) @(posedge clk);

        $display("Checked %0d replies: %0d full drops, %0d empty reads, %0d search hits",
                 replies_checked, full_drops, empty_reads, search_hits);
        $display("Mismatches: %0d, replies left pending: %0d", mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
